// ----- rtl/scpg_pkg.sv -----
package scpg_pkg;

   // Field widths
   localparam int SEED_W = 31;
   localparam int LEN_W  = 7;
   localparam int POS_W  = 6;

   // MINSTD Lehmer generator
   localparam int MULT_W = 16;
   localparam int PROD_W = SEED_W + MULT_W;
   localparam logic [MULT_W-1:0] LEHMER_MULT = 16'd48271;
   localparam logic [SEED_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;

   // Remainder unit: two dividend bits per cycle over a 32-bit word
   localparam int DIV_W    = 32;
   localparam int DCNT_W   = 4;
   localparam logic [DCNT_W-1:0] DCNT_LAST = 4'd15;

   // One shuffle job handed from the front to the back
   typedef struct packed {
      logic [SEED_W-1:0] seed;
      logic [LEN_W-1:0]  len;
   } task_type;

   // One result item
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] element;
      logic             last;
   } result_type;

endpackage

// ----- rtl/scpg_front.sv -----
module scpg_front
   import scpg_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [SEED_W-1:0] req_start_seed,
   input  logic [LEN_W-1:0]  req_perm_length,
   output logic              task_valid,
   output task_type          task_data,
   input  logic              task_pop
);

   localparam int QDEPTH = 2;

   task_type        q_mem [QDEPTH];
   logic            wptr_ff, wptr_in;
   logic            rptr_ff, rptr_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [LEN_W-1:0] len_sat;
   logic            accept;
   logic            enq;
   logic            deq;

   // Clamp the length; zero-length items produce nothing and are dropped
   assign len_sat = (req_perm_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req_perm_length;
   assign full    = (cnt_ff == 2'(QDEPTH));
   assign accept  = push && !full;
   assign enq     = accept && (len_sat != '0);
   assign deq     = task_pop && task_valid;

   assign task_valid = (cnt_ff != 2'd0);
   assign task_data  = q_mem[rptr_ff];

   // Pointer and count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (enq) begin
         wptr_in = ~wptr_ff;
      end
      if (deq) begin
         rptr_in = ~rptr_ff;
      end
      case ({enq, deq})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (enq) begin
         q_mem[wptr_ff] <= '{seed: req_start_seed, len: len_sat};
      end
   end

endmodule

// ----- rtl/scpg_back.sv -----
module scpg_back
   import scpg_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       task_valid,
   input  task_type   task_data,
   output logic       task_pop,
   output result_type rsp_data,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   localparam int AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = 2;
   localparam int OQ_CW    = 3;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_INIT = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_FOLD = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_RDI  = 4'd5;
   localparam logic [3:0] ST_RDJ  = 4'd6;
   localparam logic [3:0] ST_WRI  = 4'd7;
   localparam logic [3:0] ST_WRJ  = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   // Index store
   logic [POS_W-1:0] store_mem [MAX_LEN];
   logic [POS_W-1:0] rd_data_ff;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [POS_W-1:0] mem_wdata;

   logic [3:0]        state_ff, state_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [POS_W-1:0]  item_ff, item_in;

   // Read in flight toward the output queue
   logic              ovld_ff, ovld_in;
   logic [POS_W-1:0]  opos_ff, opos_in;
   logic              olast_ff, olast_in;

   // Output queue
   result_type        oq_mem [OQ_DEPTH];
   logic [OQ_AW-1:0]  oq_wptr_ff, oq_rptr_ff;
   logic [OQ_CW-1:0]  oq_cnt_ff, oq_cnt_in;
   logic              oq_push, oq_pop;

   logic [LEN_W-1:0]  len_m1;
   logic [DIV_W-1:0]  fold_sum;
   logic [SEED_W-1:0] fold_seed;
   logic [LEN_W-1:0]  dvsr;
   logic [LEN_W-1:0]  r1, r1s, r2, r2s;
   logic              issue;

   assign len_m1 = len_ff - LEN_W'(1);

   // Mersenne fold of the product: hi + lo, then one conditional subtract
   assign fold_sum  = {1'b0, prod_ff[SEED_W-1:0]} + DIV_W'(prod_ff[PROD_W-1:SEED_W]);
   assign fold_seed = (fold_sum >= {1'b0, LEHMER_MOD}) ?
                      SEED_W'(fold_sum - {1'b0, LEHMER_MOD}) : fold_sum[SEED_W-1:0];

   // Two restoring remainder steps per cycle, divisor is the current position
   assign dvsr = LEN_W'(pos_ff);
   assign r1   = {rem_ff, div_ff[DIV_W-1]};
   assign r1s  = (r1 >= dvsr) ? (r1 - dvsr) : r1;
   assign r2   = {r1s[POS_W-1:0], div_ff[DIV_W-2]};
   assign r2s  = (r2 >= dvsr) ? (r2 - dvsr) : r2;

   // Room in the output queue for one more read
   assign issue = ((oq_cnt_ff + OQ_CW'(ovld_ff)) < OQ_CW'(OQ_DEPTH));

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      seed_in   = seed_ff;
      len_in    = len_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      prod_in   = prod_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      item_in   = item_ff;
      ovld_in   = 1'b0;
      opos_in   = opos_ff;
      olast_in  = olast_ff;
      task_pop  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = k_ff[AW-1:0];
      mem_wdata = k_ff[POS_W-1:0];
      mem_re    = 1'b0;
      mem_raddr = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (task_valid) begin
               task_pop = 1'b1;
               seed_in  = task_data.seed;
               len_in   = task_data.len;
               k_in     = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            mem_we = 1'b1;
            k_in   = k_ff + LEN_W'(1);
            if (k_ff == len_m1) begin
               if (len_ff == LEN_W'(1)) begin
                  k_in     = '0;
                  state_in = ST_OUT;
               end else begin
                  pos_in   = len_m1[AW-1:0];
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(seed_ff) * PROD_W'(LEHMER_MULT);
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            seed_in  = fold_seed;
            div_in   = {1'b0, fold_seed};
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = r2s[POS_W-1:0];
            div_in  = {div_ff[DIV_W-3:0], 2'b00};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_LAST) begin
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            mem_re   = 1'b1;
            state_in = ST_RDJ;
         end
         ST_RDJ: begin
            item_in   = rd_data_ff;
            mem_re    = 1'b1;
            mem_raddr = rem_ff[AW-1:0];
            state_in  = ST_WRI;
         end
         ST_WRI: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = rd_data_ff;
            state_in  = ST_WRJ;
         end
         ST_WRJ: begin
            mem_we    = 1'b1;
            mem_waddr = rem_ff[AW-1:0];
            mem_wdata = item_ff;
            if (pos_ff == AW'(1)) begin
               k_in     = '0;
               state_in = ST_OUT;
            end else begin
               pos_in   = pos_ff - AW'(1);
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            mem_raddr = k_ff[AW-1:0];
            if (issue) begin
               mem_re   = 1'b1;
               ovld_in  = 1'b1;
               opos_in  = k_ff[POS_W-1:0];
               olast_in = (k_ff == len_m1);
               k_in     = k_ff + LEN_W'(1);
               if (k_ff == len_m1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff  <= seed_in;
      len_ff   <= len_in;
      k_ff     <= k_in;
      pos_ff   <= pos_in;
      prod_ff  <= prod_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      item_ff  <= item_in;
      opos_ff  <= opos_in;
      olast_ff <= olast_in;
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   // Output queue
   assign oq_push   = ovld_ff;
   assign rsp_empty = (oq_cnt_ff == '0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = oq_mem[oq_rptr_ff];

   always_comb begin
      case ({oq_push, oq_pop})
         2'b10:   oq_cnt_in = oq_cnt_ff + OQ_CW'(1);
         2'b01:   oq_cnt_in = oq_cnt_ff - OQ_CW'(1);
         default: oq_cnt_in = oq_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wptr_ff <= '0;
         oq_rptr_ff <= '0;
         oq_cnt_ff  <= '0;
      end else begin
         oq_cnt_ff <= oq_cnt_in;
         if (oq_push) begin
            oq_wptr_ff <= oq_wptr_ff + OQ_AW'(1);
         end
         if (oq_pop) begin
            oq_rptr_ff <= oq_rptr_ff + OQ_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_mem[oq_wptr_ff] <= '{position: opos_ff, element: rd_data_ff, last: olast_ff};
      end
   end

endmodule

// ----- rtl/seeded_cyclic_permutation_generator_core.sv -----
// Channel    Handshake        Payload
// request    push / full      req_start_seed[30:0], req_perm_length[6:0]
// response   pop / empty      rsp_position[5:0], rsp_element[5:0], rsp_last
//
// A run of length n loads the identity into the store, then does one swap step
// per position from n-1 down to 1 (multiply, Mersenne fold, remainder unit at
// two bits per cycle, two reads and two writes on the store), then issues one
// output item per cycle while the output queue has room.
// A two-entry request queue lets the next item be accepted during a run.
// Reset is synchronous; the store holds no reset value and needs no clearing.
// Zero-length items are accepted and produce no output.
module seeded_cyclic_permutation_generator_core
   import scpg_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [SEED_W-1:0] req_start_seed,
   input  logic [LEN_W-1:0]  req_perm_length,
   output logic              empty,
   input  logic              pop,
   output logic [POS_W-1:0]  rsp_position,
   output logic [POS_W-1:0]  rsp_element,
   output logic              rsp_last
);

   logic       task_valid;
   logic       task_pop;
   task_type   task_data;
   result_type rsp_data;

   // Front: accepts, clamps and queues requests
   scpg_front #(
      .MAX_LEN(MAX_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_start_seed  (req_start_seed),
      .req_perm_length (req_perm_length),
      .task_valid      (task_valid),
      .task_data       (task_data),
      .task_pop        (task_pop)
   );

   // Back: shuffle engine and output queue
   scpg_back #(
      .MAX_LEN(MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_data  (task_data),
      .task_pop   (task_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (empty),
      .rsp_pop    (pop)
   );

   assign rsp_position = rsp_data.position;
   assign rsp_element  = rsp_data.element;
   assign rsp_last     = rsp_data.last;

   // Results stay inside the permutation range
   a_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((32'(rsp_position) < MAX_LEN) && (32'(rsp_element) < MAX_LEN)))
      else $error("result outside permutation range");

   // Positions within a run are consecutive
   a_seq: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_last ##1 !empty) |-> (rsp_position == $past(rsp_position) + 6'd1))
      else $error("position skipped or repeated");

   // A new run starts at position zero
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && rsp_last ##1 !empty) |-> (rsp_position == '0))
      else $error("run did not start at position zero");

   // A cyclic permutation of two or more elements has no fixed point
   a_no_fixed: assert property (@(posedge clock) disable iff (reset)
      (!empty && !(rsp_last && (rsp_position == '0))) |-> (rsp_element != rsp_position))
      else $error("fixed point in cyclic permutation");

endmodule
